// ===== rtl/core/msdf_pkg.sv =====
// Package: shared constants, codes and types of the MAC sequence duplicate filter.
`timescale 1ns / 1ps
package msdf_pkg;

  localparam int Servers    = 4;   // default number of per-server sequence slots
  localparam int MacW       = 48;
  localparam int SeqW       = 40;
  localparam int IdxShift   = 40;
  localparam int TagIdxW    = MacW - IdxShift;  // server index field in the tag
  localparam int CntW       = 3;   // server_count register width
  localparam int NumMacRegs = 4;
  localparam int SrvW       = 2;   // selects one of the MAC registers
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    VerdictForward = 2'd0,
    VerdictUnknown = 2'd1,
    VerdictStale   = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgServerCount = 3'd0,
    CfgServerMac0  = 3'd1,
    CfgServerMac1  = 3'd2,
    CfgServerMac2  = 3'd3,
    CfgServerMac3  = 3'd4
  } cfg_idx_e;

  // One classified item waiting for the back end.
  typedef struct packed {
    verdict_e        verdict;
    logic [SrvW-1:0] server;
  } queue_entry_t;

  typedef logic [NumMacRegs-1:0][MacW-1:0] mac_table_t;

endpackage

// ===== rtl/core/msdf_if.sv =====
// Interfaces: input and result channels of the MAC sequence duplicate filter.
`timescale 1ns / 1ps
interface msdf_in_if;
  logic                      valid;
  logic                      ready;
  logic [msdf_pkg::MacW-1:0] tagged_mac;

  modport source (output valid, output tagged_mac, input ready);
  modport sink (input valid, input tagged_mac, output ready);
endinterface

interface msdf_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                verdict;
  logic [msdf_pkg::MacW-1:0] restored_mac;

  modport source (output valid, output verdict, output restored_mac, input ready);
  modport sink (input valid, input verdict, input restored_mac, output ready);
endinterface

// ===== rtl/core/msdf_front.sv =====
// Front end: accepts tagged MACs, checks server and sequence, updates sequence store.
`timescale 1ns / 1ps
module msdf_front #(
  parameter int SERVERS = msdf_pkg::Servers
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [msdf_pkg::MacW-1:0]       tagged_mac_i,
  input  logic [msdf_pkg::CntW-1:0]       server_count_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output msdf_pkg::queue_entry_t          push_entry_o
);
  import msdf_pkg::*;

  localparam logic [CntW-1:0] CountCap = CntW'(SERVERS);

  logic [SERVERS-1:0][SeqW-1:0] last_seq_q, last_seq_d;
  logic [TagIdxW-1:0]           tag_idx;
  logic [SeqW-1:0]              seq;
  logic [SeqW-1:0]              stored_seq;
  logic [CntW-1:0]              eff_count;
  logic                         known;
  logic                         stale;
  verdict_e                     verdict;

  assign tag_idx   = tagged_mac_i[MacW-1:IdxShift];
  assign seq       = tagged_mac_i[SeqW-1:0];
  assign eff_count = (server_count_i > CountCap) ? CountCap : server_count_i;
  assign known     = tag_idx < TagIdxW'(eff_count);

  always_comb begin
    stored_seq = '0;
    for (int k = 0; k < SERVERS; k++) begin
      if (tag_idx == TagIdxW'(k)) stored_seq = last_seq_q[k];
    end
  end

  assign stale = stored_seq >= seq;

  always_comb begin
    if (!known)     verdict = VerdictUnknown;
    else if (stale) verdict = VerdictStale;
    else            verdict = VerdictForward;
  end

  assign in_ready_o          = !queue_full_i;
  assign push_o              = in_valid_i && in_ready_o;
  assign push_entry_o.verdict = verdict;
  assign push_entry_o.server  = tag_idx[SrvW-1:0];

  always_comb begin
    last_seq_d = last_seq_q;
    for (int k = 0; k < SERVERS; k++) begin
      if (push_o && verdict == VerdictForward && tag_idx == TagIdxW'(k)) last_seq_d[k] = seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
    end else begin
      last_seq_q <= last_seq_d;
    end
  end

  // a forwarded beat always leaves its sequence in the store
  a_fwd_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && verdict == VerdictForward |=> stored_seq == $past(seq) ||
    tag_idx != $past(tag_idx))
    else $error("forwarded sequence not stored");

  // forward only for a known server
  a_fwd_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && verdict == VerdictForward |-> tag_idx < TagIdxW'(eff_count))
    else $error("forward verdict for unknown server");

endmodule

// ===== rtl/core/msdf_queue.sv =====
// Queue: short FIFO of classified items between front and back end.
`timescale 1ns / 1ps
module msdf_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  msdf_pkg::queue_entry_t push_entry_i,
  input  logic                   pop_i,
  output msdf_pkg::queue_entry_t head_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import msdf_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntQW = $clog2(QueueDepth + 1);

  queue_entry_t [QueueDepth-1:0] mem_q;
  logic [PtrW-1:0]               wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]              count_q, count_d;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CntQW'(QueueDepth);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + CntQW'(1);
    else if (!push_i && pop_i) count_d = count_q - CntQW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

// ===== rtl/core/msdf_back.sv =====
// Back end: pops classified items, picks the restored MAC, holds the result beat.
`timescale 1ns / 1ps
module msdf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msdf_pkg::queue_entry_t    head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  input  msdf_pkg::mac_table_t      server_mac_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                verdict_o,
  output logic [msdf_pkg::MacW-1:0] restored_mac_o
);
  import msdf_pkg::*;

  logic            valid_q, valid_d;
  verdict_e        verdict_q;
  logic [MacW-1:0] mac_q, mac_d;

  assign pop_o   = !empty_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);
  assign mac_d   = (head_i.verdict == VerdictForward) ? server_mac_i[head_i.server] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= head_i.verdict;
      mac_q     <= mac_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign verdict_o      = verdict_q;
  assign restored_mac_o = mac_q;

  // dropped beats carry a zero MAC
  a_drop_zero_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && verdict_q != VerdictForward |-> mac_q == '0)
    else $error("dropped beat with nonzero MAC");

endmodule

// ===== rtl/core/mac_sequence_duplicate_filter_unit.sv =====
// Top level: MAC sequence duplicate filter with config registers, front, queue and back.
`timescale 1ns / 1ps
// Takes one tagged source MAC per beat (bits 47:40 server index, bits 39:0
// sequence) and returns one result beat per input: forward with the server's
// configured MAC, drop as unknown server (index not below server_count, capped
// at SERVERS), or drop as duplicate/stale (sequence not above the last one
// forwarded for that server). Sustained rate is one beat per clock while results
// are taken; a full queue stalls input. The front end does the per-server lookup,
// compare and store update in the accept cycle, so a following beat for the same
// server sees the new value immediately. The accept edge writes the queue, and
// result valid rises when the back end then loads the output register from the
// queue head. The two-entry queue keeps input ready independent of output ready
// in the same cycle. Sequence store resets to zero, so sequence 0 is always
// dropped. Config writes are expected only while the filter is idle.
module mac_sequence_duplicate_filter_unit #(
  parameter int SERVERS = msdf_pkg::Servers
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  msdf_in_if.sink                      in_i,
  msdf_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [msdf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [msdf_pkg::MacW-1:0]    cfg_wdata_i
);
  import msdf_pkg::*;

  // config registers
  logic [CntW-1:0] server_count_q;
  mac_table_t      server_mac_q;

  // front to queue to back
  logic         push;
  queue_entry_t push_entry;
  logic         pop;
  queue_entry_t head;
  logic         q_empty;
  logic         q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= '0;
      server_mac_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgServerCount: server_count_q  <= cfg_wdata_i[CntW-1:0];
        CfgServerMac0:  server_mac_q[0] <= cfg_wdata_i;
        CfgServerMac1:  server_mac_q[1] <= cfg_wdata_i;
        CfgServerMac2:  server_mac_q[2] <= cfg_wdata_i;
        CfgServerMac3:  server_mac_q[3] <= cfg_wdata_i;
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  msdf_front #(
    .SERVERS(SERVERS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .tagged_mac_i  (in_i.tagged_mac),
    .server_count_i(server_count_q),
    .queue_full_i  (q_full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  msdf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  msdf_back u_back (
    .clk_i,
    .rst_ni,
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .server_mac_i  (server_mac_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .verdict_o     (out_o.verdict),
    .restored_mac_o(out_o.restored_mac)
  );

endmodule
